// ===== rtl/cbm_pkg.sv =====
// Shared types, constants and codes for the cartridge bank mapper.
// Used by cbm_xlate and cartridge_bank_mapper_core; depends on nothing.
package cbm_pkg;

  // Bank number widths kept in the translated addresses
  localparam int unsigned PRG_BANK_BITS = 6;
  localparam int unsigned CHR_BANK_BITS = 9;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned MADDR_W  = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Largest work RAM size exponent (8K)
  localparam logic [3:0] WRAM_LOG2_MAX = 4'd13;

  // Mirroring writes of this value are dropped
  localparam logic [7:0] MIRROR_IGNORE = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE = 2'd0,
    FUNC_CPU_READ  = 2'd1,
    FUNC_PPU_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_PRG   = 3'd1,
    TGT_CHR   = 3'd2,
    TGT_WRAM  = 3'd3,
    TGT_LATCH = 3'd4
  } target_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_TYPE  = 3'd0,
    CFG_A0_BIT     = 3'd1,
    CFG_A1_BIT     = 3'd2,
    CFG_LAST_PRG   = 3'd3,
    CFG_WRAM_LOG2  = 3'd4
  } cfg_idx_e;

  // Upper address nibbles of the register windows
  typedef enum logic [3:0] {
    NIB_PRG0   = 4'h8,
    NIB_MIRROR = 4'h9,
    NIB_PRG1   = 4'hA,
    NIB_CHR0   = 4'hB,
    NIB_IRQ    = 4'hF
  } reg_nib_e;

  // Select codes in the 0x9xxx window
  typedef enum logic [1:0] {
    SEL_MIRROR0 = 2'd0,
    SEL_MIRROR1 = 2'd1,
    SEL_SWAP    = 2'd2,
    SEL_EXT     = 2'd3
  } sel_e;

  typedef struct packed {
    logic       chip_type;
    logic [2:0] a0_bit;
    logic [2:0] a1_bit;
    logic [7:0] last_prg_bank;
    logic [3:0] wram_size_log2;
  } cfg_t;

  typedef struct packed {
    logic [1:0][7:0]  prg_bank;
    logic [7:0][11:0] chr_bank;
    logic             prg_swap;
    logic [1:0]       mirror;
    logic [7:0]       wire_latch;
  } state_t;

  typedef struct packed {
    logic [2:0]         target;
    logic [MADDR_W-1:0] mapped_addr;
    logic [7:0]         read_data;
    logic [1:0]         mirror_mode;
    logic               irq_write;
    logic [1:0]         irq_port;
    logic [7:0]         irq_data;
    logic               ext_select;
    logic [7:0]         wire_value;
  } result_t;

endpackage

// ===== rtl/cbm_xlate.sv =====
// Bus access decode: register updates and address translation for one transaction.
// Purely combinational; depends on cbm_pkg.
module cbm_xlate (
  input  cbm_pkg::cfg_t                  cfg_i,
  input  cbm_pkg::state_t                st_i,
  input  logic [1:0]                     func_i,
  input  logic [cbm_pkg::ADDR_W-1:0]     addr_i,
  input  logic [7:0]                     data_i,
  input  logic [7:0]                     open_bus_i,
  output cbm_pkg::state_t                st_o,
  output cbm_pkg::result_t               res_o
);

  logic                             s0, s1;
  logic [1:0]                       sel;
  logic [3:0]                       wl;
  logic [12:0]                      wmask;
  logic                             in_wram;
  logic                             hi_area;
  logic [3:0]                       nib;
  logic [1:0]                       nib_off;
  logic [2:0]                       chr_k;
  logic [11:0]                      chr_cur;
  logic [1:0]                       win;
  logic [7:0]                       prg_full;
  logic [cbm_pkg::PRG_BANK_BITS-1:0] prg_b;
  logic [2:0]                       chr_slot;
  logic [cbm_pkg::CHR_BANK_BITS-1:0] chr_b;

  // Decode select lines, work RAM window and bank numbers
  always_comb begin
    s0      = addr_i[cfg_i.a0_bit];
    s1      = addr_i[cfg_i.a1_bit];
    sel     = {s1, s0};
    wl      = (cfg_i.wram_size_log2 > cbm_pkg::WRAM_LOG2_MAX) ?
              cbm_pkg::WRAM_LOG2_MAX : cfg_i.wram_size_log2;
    wmask   = (13'd1 << wl) - 13'd1;
    in_wram = (addr_i[15:13] == 3'b011);
    hi_area = addr_i[15];
    nib     = addr_i[15:12];
    nib_off = 2'(nib - cbm_pkg::NIB_CHR0);
    chr_k   = {nib_off, s1};
    chr_cur = st_i.chr_bank[chr_k];

    // PRG window, with windows 0 and 2 traded in swap mode
    win = addr_i[14:13];
    if (st_i.prg_swap && !win[0]) begin
      win = win ^ 2'b10;
    end
    if (win[1]) begin
      prg_full = cfg_i.last_prg_bank - 8'd1 + {7'd0, win[0]};
    end else begin
      prg_full = st_i.prg_bank[win[0]];
    end
    prg_b    = prg_full[cbm_pkg::PRG_BANK_BITS-1:0];
    chr_slot = addr_i[12:10];
    chr_b    = st_i.chr_bank[chr_slot][cbm_pkg::CHR_BANK_BITS-1:0];
  end

  // Apply the transaction
  always_comb begin
    st_o = st_i;
    res_o = '0;
    res_o.target = cbm_pkg::TGT_NONE;

    unique case (func_i)
      cbm_pkg::FUNC_CPU_WRITE: begin
        if (in_wram) begin
          if (wl != 4'd0) begin
            res_o.target      = cbm_pkg::TGT_WRAM;
            res_o.mapped_addr = cbm_pkg::MADDR_W'(addr_i[12:0] & wmask);
          end else if (!cfg_i.chip_type) begin
            st_o.wire_latch = data_i;
          end
        end else if (hi_area) begin
          unique case (nib)
            cbm_pkg::NIB_PRG0, cbm_pkg::NIB_PRG1: begin
              st_o.prg_bank[addr_i[13]] = data_i;
            end
            cbm_pkg::NIB_MIRROR: begin
              unique case (sel & {2{cfg_i.chip_type}})
                cbm_pkg::SEL_MIRROR0, cbm_pkg::SEL_MIRROR1: begin
                  if (data_i != cbm_pkg::MIRROR_IGNORE) begin
                    st_o.mirror = data_i[1:0];
                  end
                end
                cbm_pkg::SEL_SWAP: st_o.prg_swap = data_i[1];
                default:           res_o.ext_select = 1'b1;
              endcase
            end
            cbm_pkg::NIB_IRQ: begin
              res_o.irq_write = 1'b1;
              res_o.irq_port  = sel;
              res_o.irq_data  = data_i;
            end
            default: begin
              // CHR bank registers load the low nibble, or with s0 set the upper eight bits
              if (s0) begin
                st_o.chr_bank[chr_k] = {data_i, chr_cur[3:0]};
              end else begin
                st_o.chr_bank[chr_k] = {chr_cur[11:4], data_i[3:0]};
              end
            end
          endcase
        end
      end
      cbm_pkg::FUNC_CPU_READ: begin
        if (in_wram) begin
          if (wl != 4'd0) begin
            res_o.target      = cbm_pkg::TGT_WRAM;
            res_o.mapped_addr = cbm_pkg::MADDR_W'(addr_i[12:0] & wmask);
          end else if (!cfg_i.chip_type && (addr_i[12:0] == 13'd0)) begin
            res_o.target    = cbm_pkg::TGT_LATCH;
            res_o.read_data = {open_bus_i[7:1], st_i.wire_latch[0]};
          end
        end else if (hi_area) begin
          res_o.target      = cbm_pkg::TGT_PRG;
          res_o.mapped_addr = cbm_pkg::MADDR_W'({prg_b, addr_i[12:0]});
        end
      end
      cbm_pkg::FUNC_PPU_READ: begin
        res_o.target      = cbm_pkg::TGT_CHR;
        res_o.mapped_addr = cbm_pkg::MADDR_W'({chr_b, addr_i[9:0]});
      end
      default: begin
        // no access
      end
    endcase

    // Status after the transaction
    if (cfg_i.chip_type && st_o.mirror[1]) begin
      res_o.mirror_mode = {1'b1, st_o.mirror[0]};
    end else begin
      res_o.mirror_mode = {1'b0, ~st_o.mirror[0]};
    end
    res_o.wire_value = st_o.wire_latch;
  end

endmodule

// ===== rtl/cartridge_bank_mapper_core.sv =====
// Result: registered, and valid in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; a new input is taken while the result
// register drains, and input stalls only when that register is full and not taken.
// Reset: bank registers return to their power-on values, configuration to its
// defaults, the result register empties. No clearing pass.
// Top level of the cartridge bank mapper; depends on cbm_pkg and cbm_xlate.
module cartridge_bank_mapper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // bus access input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [cbm_pkg::ADDR_W-1:0]          addr_i,
  input  logic [7:0]                          data_i,
  input  logic [7:0]                          open_bus_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          target_o,
  output logic [cbm_pkg::MADDR_W-1:0]         mapped_addr_o,
  output logic [7:0]                          read_data_o,
  output logic [1:0]                          mirror_mode_o,
  output logic                                irq_write_o,
  output logic [1:0]                          irq_port_o,
  output logic [7:0]                          irq_data_o,
  output logic                                ext_select_o,
  output logic [7:0]                          wire_value_o
);

  cbm_pkg::cfg_t    cfg_q;
  cbm_pkg::state_t  st_q, st_d;
  cbm_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_type      <= 1'b1;
      cfg_q.a0_bit         <= 3'd0;
      cfg_q.a1_bit         <= 3'd1;
      cfg_q.last_prg_bank  <= 8'hFF;
      cfg_q.wram_size_log2 <= 4'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cbm_pkg::CFG_CHIP_TYPE: cfg_q.chip_type      <= cfg_data_i[0];
        cbm_pkg::CFG_A0_BIT:    cfg_q.a0_bit         <= cfg_data_i[2:0];
        cbm_pkg::CFG_A1_BIT:    cfg_q.a1_bit         <= cfg_data_i[2:0];
        cbm_pkg::CFG_LAST_PRG:  cfg_q.last_prg_bank  <= cfg_data_i;
        cbm_pkg::CFG_WRAM_LOG2: cfg_q.wram_size_log2 <= cfg_data_i[3:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Decode and translate the incoming transaction
  cbm_xlate u_xlate (
    .cfg_i      (cfg_q),
    .st_i       (st_q),
    .func_i     (func_i),
    .addr_i     (addr_i),
    .data_i     (data_i),
    .open_bus_i (open_bus_i),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  // Mapper state advances on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.prg_bank[0] <= 8'd0;
      st_q.prg_bank[1] <= 8'd1;
      for (int i = 0; i < 8; i++) begin
        st_q.chr_bank[i] <= 12'(i);
      end
      st_q.prg_swap   <= 1'b0;
      st_q.mirror     <= 2'd0;
      st_q.wire_latch <= 8'd0;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = res_q.target;
  assign mapped_addr_o = res_q.mapped_addr;
  assign read_data_o   = res_q.read_data;
  assign mirror_mode_o = res_q.mirror_mode;
  assign irq_write_o   = res_q.irq_write;
  assign irq_port_o    = res_q.irq_port;
  assign irq_data_o    = res_q.irq_data;
  assign ext_select_o  = res_q.ext_select;
  assign wire_value_o  = res_q.wire_value;

endmodule
